@@ src/tcg_pkg.sv @@
// Package for the text cursor glyph command generator.
// Holds the word layouts, character and function codes and fixed cell geometry.
// No dependencies.
package tcg_pkg;

	// fixed glyph cell edge in pixels
	localparam int unsigned CELL = 8;
	// right limit of the cursor x register
	localparam logic [11:0] X_MAX = 12'hFFF;

	// function codes carried in s_tuser
	localparam logic [1:0] FN_CHAR    = 2'd0;
	localparam logic [1:0] FN_SET_POS = 2'd1;
	localparam logic [1:0] FN_BEGIN   = 2'd2;

	// control characters
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// bus widths
	localparam int unsigned IN_W   = 24;
	localparam int unsigned USER_W = 2;
	localparam int unsigned OUT_W  = 80;

	// one input word after unpacking
	typedef struct packed {
		logic [1:0]        func;
		logic [7:0]        char_code;
		logic signed [7:0] grid_x;
		logic signed [7:0] grid_y;
	} in_item_t;

	// one textured rectangle command
	typedef struct packed {
		logic [1:0]  palette_index;
		logic        palette_load;
		logic [12:0] tex_t;
		logic [8:0]  tex_s;
		logic [9:0]  rect_lry;
		logic [14:0] rect_lrx;
		logic [9:0]  rect_uly;
		logic [13:0] rect_ulx;
	} glyph_cmd_t;

endpackage

@@ src/tcg_cursor.sv @@
// Cursor and palette cache state with the per-word command logic.
// Depends on tcg_pkg for codes, cell size and the item/command structs.
module tcg_cursor #(
	parameter int unsigned SCREEN_W  = 320,
	parameter int unsigned SCREEN_H  = 240,
	parameter int unsigned TAB_CELLS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  tcg_pkg::in_item_t  item,
	output logic               emit,
	output tcg_pkg::glyph_cmd_t cmd
);
	import tcg_pkg::*;

	// tab stop spacing in pixels and the width of the phase within one stop
	localparam int unsigned STOP = TAB_CELLS * CELL;
	localparam int unsigned PW   = $clog2(STOP);
	localparam int unsigned PW1  = PW + 1;

	localparam logic [12:0]   W_PIX    = 13'(SCREEN_W);
	localparam logic [12:0]   W_CELLS  = 13'(SCREEN_W / CELL);
	localparam logic [11:0]   X_EDGE   = 12'(SCREEN_W - CELL);
	localparam logic [PW-1:0] PH_EDGE  = PW'((SCREEN_W - CELL) % STOP);
	localparam logic [PW-1:0] PH_SAT   = PW'(4095 % STOP);
	localparam logic [PW1-1:0] STOP_V  = PW1'(STOP);
	localparam logic [8:0]    H_PIX    = 9'(SCREEN_H);
	localparam logic [8:0]    H_CELLS  = 9'(SCREEN_H / CELL);
	localparam logic [7:0]    Y_EDGE   = 8'(SCREEN_H - CELL);

	logic [11:0]   x_q;
	logic [PW-1:0] ph_q;
	logic [7:0]    y_q;
	logic [1:0]    pal_q;
	logic          pal_valid_q;

	logic [11:0]   x_d;
	logic [PW-1:0] ph_d;
	logic [7:0]    y_d;
	logic [1:0]    pal_d;
	logic          pal_valid_d;

	logic [12:0]   x_adv;
	logic [PW1-1:0] ph_adv;
	logic [12:0]   tab_target;
	logic [8:0]    y_adv;
	logic [7:0]    y_lf;
	logic [6:0]    gx_mod;
	logic [1:0]    idx;

	// remainder of a column count by the tab spacing, one conditional subtract per bit
	function automatic logic [6:0] cell_mod(input logic [6:0] v);
		logic [6:0]  r;
		logic [13:0] sub;
		r = v;
		for (int k = 6; k >= 0; k--) begin
			sub = 14'(TAB_CELLS) << k;
			if ({7'd0, r} >= sub) begin
				r = r - sub[6:0];
			end
		end
		return r;
	endfunction

	// shared arithmetic for the step
	always_comb begin
		x_adv      = {1'b0, x_q} + 13'(CELL);
		ph_adv     = {1'b0, ph_q} + PW1'(CELL);
		tab_target = {1'b0, x_q} - 13'(ph_q) + 13'(STOP);
		y_adv      = {1'b0, y_q} + 9'(CELL);
		y_lf       = (y_adv >= H_PIX) ? 8'd0 : y_adv[7:0];
		gx_mod     = cell_mod(item.grid_x[6:0]);
		idx        = item.char_code[1:0];
	end

	// command fields come from the cursor before it moves
	always_comb begin
		cmd.rect_ulx      = {x_q, 2'b00};
		cmd.rect_uly      = {y_q, 2'b00};
		cmd.rect_lrx      = 15'({x_adv, 2'b00});
		cmd.rect_lry      = 10'({y_adv, 2'b00});
		cmd.tex_s         = {item.char_code[2], 8'd0};
		cmd.tex_t         = {item.char_code[7:3], 8'd0};
		cmd.palette_load  = !pal_valid_q || (pal_q != idx);
		cmd.palette_index = idx;
	end

	// decode the word and compute next state
	always_comb begin
		x_d         = x_q;
		ph_d        = ph_q;
		y_d         = y_q;
		pal_d       = pal_q;
		pal_valid_d = pal_valid_q;
		emit        = 1'b0;
		case (item.func)
			FN_SET_POS: begin
				// clamp column: negative to zero, past the edge to the last cell
				if (item.grid_x[7]) begin
					x_d  = 12'd0;
					ph_d = '0;
				end else if ({5'd0, item.grid_x} >= W_CELLS) begin
					x_d  = X_EDGE;
					ph_d = PH_EDGE;
				end else begin
					x_d  = {2'b00, item.grid_x[6:0], 3'b000};
					ph_d = PW'({gx_mod, 3'b000});
				end
				// clamp row the same way
				if (item.grid_y[7]) begin
					y_d = 8'd0;
				end else if ({1'b0, item.grid_y} >= H_CELLS) begin
					y_d = Y_EDGE;
				end else begin
					y_d = {item.grid_y[4:0], 3'b000};
				end
			end
			FN_BEGIN: begin
				pal_valid_d = 1'b0;
			end
			FN_CHAR: begin
				if (item.char_code == CH_TAB) begin
					x_d  = 12'd0;
					ph_d = '0;
					if (tab_target >= W_PIX) begin
						y_d = y_lf;
					end else begin
						x_d = tab_target[11:0];
					end
				end else if (item.char_code == CH_LF || item.char_code == CH_CR) begin
					x_d  = 12'd0;
					ph_d = '0;
					y_d  = y_lf;
				end else if (item.char_code != CH_NUL) begin
					emit        = 1'b1;
					pal_d       = idx;
					pal_valid_d = 1'b1;
					// advance one cell, saturate at the right limit
					if (x_adv > {1'b0, X_MAX}) begin
						x_d  = X_MAX;
						ph_d = PH_SAT;
					end else begin
						x_d  = x_adv[11:0];
						ph_d = (ph_adv >= STOP_V) ? PW'(ph_adv - STOP_V) : ph_adv[PW-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state registers, updated once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			ph_q        <= '0;
			y_q         <= '0;
			pal_q       <= '0;
			pal_valid_q <= 1'b0;
		end else if (step) begin
			x_q         <= x_d;
			ph_q        <= ph_d;
			y_q         <= y_d;
			pal_q       <= pal_d;
			pal_valid_q <= pal_valid_d;
		end
	end

endmodule

@@ src/tcg_out_reg.sv @@
// Output register for glyph commands: holds a word until the master side takes it.
// Depends on tcg_pkg for the command struct and bus width.
module tcg_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  tcg_pkg::glyph_cmd_t        cmd,
	input  logic                       ready,
	output logic                       valid,
	output logic [tcg_pkg::OUT_W-1:0]  data
);
	import tcg_pkg::*;

	logic       valid_q;
	glyph_cmd_t cmd_q;

	// valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd;
		end
	end

	assign valid = valid_q;
	assign data  = {(OUT_W - $bits(glyph_cmd_t))'(0), cmd_q};

endmodule

@@ src/text_cursor_glyph_command_gen.sv @@
// Top level of the text cursor glyph command generator.
// Depends on tcg_pkg, tcg_cursor and tcg_out_reg.
//
//  channel | dir | fields (low bit up)
//  s_*     | in  | tdata: char_code, grid_x, grid_y; tuser: func
//  m_*     | out | tdata: rect_ulx, rect_uly, rect_lrx, rect_lry, tex_s, tex_t,
//          |     |        palette_load, palette_index, zero pad
//
// One word per cycle while the output is not stalled. A word is taken into the
// input register, decoded by the cursor logic once the output register is free
// and, if it draws a glyph, lands in the output register. The cursor and palette
// registers update when the word is decoded, which sets the rate.
// Reset clears the cursor to the top left and invalidates the palette cache.
// A stalled output holds a full input register and drops s_tready; an empty
// input register still takes one word.
module text_cursor_glyph_command_gen #(
	parameter int unsigned SCREEN_W  = 320,
	parameter int unsigned SCREEN_H  = 240,
	parameter int unsigned TAB_CELLS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tcg_pkg::IN_W-1:0]    s_tdata,   // char_code, grid_x, grid_y
	input  logic [tcg_pkg::USER_W-1:0]  s_tuser,   // func
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// rect_ulx, rect_uly, rect_lrx, rect_lry, tex_s, tex_t, palette_load,
	// palette_index, zero pad
	output logic [tcg_pkg::OUT_W-1:0]   m_tdata
);
	import tcg_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       advance;
	logic       step;
	logic       emit;
	glyph_cmd_t cmd;

	// decode may run when the output register is free or being emptied
	assign advance  = !m_tvalid || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func      <= s_tuser;
			item_s1.char_code <= s_tdata[7:0];
			item_s1.grid_x    <= s_tdata[15:8];
			item_s1.grid_y    <= s_tdata[23:16];
		end
	end

	tcg_cursor #(
		.SCREEN_W  (SCREEN_W),
		.SCREEN_H  (SCREEN_H),
		.TAB_CELLS (TAB_CELLS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.emit   (emit),
		.cmd    (cmd)
	);

	tcg_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && emit),
		.cmd    (cmd),
		.ready  (m_tready),
		.valid  (m_tvalid),
		.data   (m_tdata)
	);

endmodule

@@ src/tcg_checker.sv @@
// Port-level checks for the text cursor glyph command generator.
// Depends only on the top level's ports; bound to it at the end of this file.
module tcg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	// no word is offered while reset is applied
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("m_tvalid high during reset");

	// a stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

	// input only stalls behind a stalled output word
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// glyph box is one cell wide and tall
	a_geometry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[38:24] == {1'b0, m_tdata[13:0]} + 15'd32)
			&& (m_tdata[48:39] == m_tdata[23:14] + 10'd32))
		else $error("glyph rectangle is not one cell");

	// texture origin on glyph boundaries, pad bits clear
	a_tex_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[56:49] == 8'd0) && (m_tdata[65:58] == 8'd0)
			&& (m_tdata[79:74] == 6'd0))
		else $error("texture origin misaligned or pad bits set");

endmodule

bind text_cursor_glyph_command_gen tcg_checker u_tcg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
